/* design/sws_pkg.sv */
// Shared constants, codes and controller/datapath types for the window sender.
package sws_pkg;

   localparam int unsigned POS_WIDTH  = 32;
   localparam int unsigned SIZE_WIDTH = 11;
   localparam int unsigned WIN_WIDTH  = 7;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [SIZE_WIDTH-1:0] CHUNK_BYTES = 11'd1024;
   localparam logic [WIN_WIDTH-1:0]  MAX_WINDOW  = 7'd64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILE_LENGTH    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_PACKETS = 2'd1;

   typedef enum logic [1:0] {
      OP_SEND     = 2'd0,
      OP_ACK      = 2'd1,
      OP_TIMEOUT  = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_PACKET    = 3'd0,
      KIND_ACK_TAKEN = 3'd1,
      KIND_IGNORED   = 3'd2,
      KIND_CORRUPT   = 3'd3,
      KIND_FINISHED  = 3'd4,
      KIND_TIMEOUT   = 3'd5,
      KIND_NOTHING   = 3'd6
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SEND = 1'b1
   } state_type;

   typedef struct packed {
      logic load_single;
      logic start_round;
      logic emit_packet;
   } cmd_type;

   typedef struct packed {
      logic send_ok;
      logic pkt_last;
      logic out_free;
   } status_type;

endpackage

/* design/sws_req_if.sv */
// Request channel: valid/ready handshake carrying one event beat.
interface sws_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] ack_number;
   logic        ack_fin;
   logic        ack_corrupt;

   modport source (output valid, output operation, output ack_number,
                   output ack_fin, output ack_corrupt, input ready);
   modport sink (input valid, input operation, input ack_number,
                 input ack_fin, input ack_corrupt, output ready);
endinterface

/* design/sws_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result beat.
interface sws_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] packet_offset;
   logic [10:0] packet_size;
   logic        packet_fin;
   logic [31:0] window_base;
   logic        last;

   modport source (output valid, output kind, output packet_offset,
                   output packet_size, output packet_fin, output window_base,
                   output last, input ready);
   modport sink (input valid, input kind, input packet_offset,
                 input packet_size, input packet_fin, input window_base,
                 input last, output ready);
endinterface

/* design/sws_ctrl.sv */
// Controller state machine: accepts events and sequences the packets of a round.
module sws_ctrl
   import sws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  op_type     req_op,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_SEND && status.send_ok) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (status.out_free && status.pkt_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_SEND && status.send_ok) begin
                  cmd.start_round = 1'b1;
               end else begin
                  cmd.load_single = 1'b1;
               end
            end
         end
         ST_SEND: begin
            cmd.emit_packet = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* design/sws_datapath.sv */
// Datapath: window state, configuration registers, packet cursor and result register.
module sws_datapath
   import sws_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  op_type                     req_op,
   input  logic [POS_WIDTH-1:0]       req_ack_number,
   input  logic                       req_ack_fin,
   input  logic                       req_ack_corrupt,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output kind_type                   rsp_kind,
   output logic [POS_WIDTH-1:0]       rsp_offset,
   output logic [SIZE_WIDTH-1:0]      rsp_size,
   output logic                       rsp_fin,
   output logic [POS_WIDTH-1:0]       rsp_base,
   output logic                       rsp_last
);

   logic [POS_WIDTH-1:0] file_len_ff;
   logic [WIN_WIDTH-1:0] window_ff;

   logic [POS_WIDTH-1:0] base_ff, base_in;
   logic [WIN_WIDTH-1:0] sent_ff, sent_in;
   logic [WIN_WIDTH-1:0] acks_ff, acks_in;
   logic                 open_ff, open_in;
   logic                 done_ff, done_in;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [WIN_WIDTH-1:0] count_ff, count_in;

   logic                  out_valid_ff, out_valid_in;
   kind_type              out_kind_ff, out_kind_in;
   logic [POS_WIDTH-1:0]  out_offset_ff, out_offset_in;
   logic [SIZE_WIDTH-1:0] out_size_ff, out_size_in;
   logic                  out_fin_ff, out_fin_in;
   logic [POS_WIDTH-1:0]  out_base_ff, out_base_in;
   logic                  out_last_ff, out_last_in;

   logic [WIN_WIDTH-1:0] win_eff;
   logic [POS_WIDTH:0]   pos_next_ext;
   logic [POS_WIDTH:0]   base_next_ext;
   logic [POS_WIDTH-1:0] remaining;
   logic                 pkt_fin;
   logic [SIZE_WIDTH-1:0] pkt_size;
   logic [WIN_WIDTH-1:0] count_next;
   logic                 ack_in_range;

   // A window of zero behaves as one; anything above the maximum is clamped.
   always_comb begin
      if (window_ff == '0) begin
         win_eff = WIN_WIDTH'(1);
      end else if (window_ff > MAX_WINDOW) begin
         win_eff = MAX_WINDOW;
      end else begin
         win_eff = window_ff;
      end
   end

   assign pos_next_ext  = {1'b0, pos_ff} + (POS_WIDTH+1)'(CHUNK_BYTES);
   assign base_next_ext = {1'b0, base_ff} + (POS_WIDTH+1)'(CHUNK_BYTES);
   assign remaining     = file_len_ff - pos_ff;
   assign pkt_fin       = pos_next_ext >= {1'b0, file_len_ff};
   assign pkt_size      = (remaining < POS_WIDTH'(CHUNK_BYTES)) ?
                          remaining[SIZE_WIDTH-1:0] : CHUNK_BYTES;
   assign count_next    = count_ff + WIN_WIDTH'(1);
   assign ack_in_range  = (req_ack_number > base_ff) &&
                          ({1'b0, req_ack_number} <= base_next_ext);

   assign status.send_ok  = !done_ff && (base_ff < file_len_ff);
   assign status.pkt_last = pkt_fin || (count_next >= win_eff);
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_len_ff <= '0;
         window_ff   <= WIN_WIDTH'(1);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_FILE_LENGTH) begin
            file_len_ff <= csr_write_data[POS_WIDTH-1:0];
         end else if (csr_index == CSR_WINDOW_PACKETS) begin
            window_ff <= csr_write_data[WIN_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      base_in       = base_ff;
      sent_in       = sent_ff;
      acks_in       = acks_ff;
      open_in       = open_ff;
      done_in       = done_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_offset_in = out_offset_ff;
      out_size_in   = out_size_ff;
      out_fin_in    = out_fin_ff;
      out_base_in   = out_base_ff;
      out_last_in   = out_last_ff;

      if (cmd.start_round) begin
         open_in  = 1'b0;
         pos_in   = base_ff;
         count_in = '0;
      end

      if (cmd.emit_packet) begin
         out_valid_in  = 1'b1;
         out_kind_in   = KIND_PACKET;
         out_offset_in = pos_ff;
         out_size_in   = pkt_size;
         out_fin_in    = pkt_fin;
         out_base_in   = base_ff;
         out_last_in   = status.pkt_last;
         pos_in        = pos_next_ext[POS_WIDTH-1:0];
         count_in      = count_next;
         if (status.pkt_last) begin
            open_in = 1'b1;
            sent_in = count_next;
            acks_in = '0;
         end
      end

      if (cmd.load_single) begin
         out_valid_in  = 1'b1;
         out_offset_in = '0;
         out_size_in   = '0;
         out_fin_in    = 1'b0;
         out_last_in   = 1'b1;
         out_kind_in   = KIND_IGNORED;
         case (req_op)
            OP_SEND: begin
               // Only reached when there is nothing left to send.
               open_in     = 1'b0;
               out_kind_in = KIND_NOTHING;
            end
            OP_ACK: begin
               if (open_ff && !done_ff) begin
                  if (req_ack_fin) begin
                     done_in     = 1'b1;
                     open_in     = 1'b0;
                     out_kind_in = KIND_FINISHED;
                  end else if (req_ack_corrupt) begin
                     open_in     = 1'b0;
                     out_kind_in = KIND_CORRUPT;
                  end else if (ack_in_range) begin
                     base_in = base_next_ext[POS_WIDTH] ? '1 :
                               base_next_ext[POS_WIDTH-1:0];
                     acks_in = acks_ff + WIN_WIDTH'(1);
                     if ((acks_ff + WIN_WIDTH'(1)) >= sent_ff) begin
                        open_in = 1'b0;
                     end
                     out_kind_in = KIND_ACK_TAKEN;
                  end
               end
            end
            OP_TIMEOUT: begin
               open_in     = 1'b0;
               out_kind_in = KIND_TIMEOUT;
            end
            default: out_kind_in = KIND_IGNORED;
         endcase
         out_base_in = base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         sent_ff      <= '0;
         acks_ff      <= '0;
         open_ff      <= 1'b0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         sent_ff      <= sent_in;
         acks_ff      <= acks_in;
         open_ff      <= open_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      count_ff      <= count_in;
      out_kind_ff   <= out_kind_in;
      out_offset_ff <= out_offset_in;
      out_size_ff   <= out_size_in;
      out_fin_ff    <= out_fin_in;
      out_base_ff   <= out_base_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_offset = out_offset_ff;
   assign rsp_size   = out_size_ff;
   assign rsp_fin    = out_fin_ff;
   assign rsp_base   = out_base_ff;
   assign rsp_last   = out_last_ff;

endmodule

/* design/sliding_window_sender_core.sv */
// Go-back-N sender control: top level joining the controller and the datapath.
// Ack, timeout and idle send events: the result is registered in the cycle after the request beat.
// A send round: the request enters the send state, which registers one packet per cycle
// while the response side takes them; the next request is taken after the round's last packet.
// Throughput is set by the single result register shared by all events.
// Synchronous active-high reset clears window state, sets file length 0 and window 1.
module sliding_window_sender_core
   import sws_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   sws_req_if.sink                    req_bus,
   sws_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cmd_type    cmd;
   status_type status;
   op_type     req_op;
   kind_type   rsp_kind;
   logic       req_ready;

   assign req_op        = op_type'(req_bus.operation);
   assign req_bus.ready = req_ready;
   assign rsp_bus.kind  = rsp_kind;

   sws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_op),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   sws_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_op           (req_op),
      .req_ack_number   (req_bus.ack_number),
      .req_ack_fin      (req_bus.ack_fin),
      .req_ack_corrupt  (req_bus.ack_corrupt),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_kind         (rsp_kind),
      .rsp_offset       (rsp_bus.packet_offset),
      .rsp_size         (rsp_bus.packet_size),
      .rsp_fin          (rsp_bus.packet_fin),
      .rsp_base         (rsp_bus.window_base),
      .rsp_last         (rsp_bus.last)
   );

   // A request is only taken when the result register can take its beat.
   a_ready_needs_slot: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("request taken while result register is blocked");

   // Every beat other than a packet is the only result of its request.
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_kind != KIND_PACKET) |-> rsp_bus.last)
      else $error("non-packet result without last");

   // Packet sizes stay within one chunk and are never empty.
   a_packet_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_kind == KIND_PACKET) |->
      (rsp_bus.packet_size != '0 && rsp_bus.packet_size <= CHUNK_BYTES))
      else $error("packet size out of range");

   // No request is taken while a round is still emitting packets.
   a_round_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_packet |-> !req_bus.ready)
      else $error("request taken during a send round");

endmodule
